>>> rtl/core/ddm_pkg.sv
// ddm_pkg: shared types and constants of the differential drive mixer
// used by the channel interfaces and every rtl module of the block
`default_nettype none

package ddm_pkg;

    localparam int LVL_W   = 5;
    localparam int TRIM_W  = 5;
    localparam int DIR_W   = 2;
    localparam int LIMIT_W = 10;
    localparam int CMP_W   = 8;

    typedef enum logic [2:0] {
        OP_ADJUST  = 3'd0,
        OP_SET_SPD = 3'd1,
        OP_SET_HDG = 3'd2,
        OP_RESTORE = 3'd3,
        OP_TURN    = 3'd4
    } cmd_op_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_LEFT  = 2'd2
    } turn_dir_t;

    // levels held after a command, plus the beat that goes with them
    typedef struct packed {
        logic                     valid;
        logic                     started;
        logic signed [LVL_W-1:0]  speed;
        logic signed [LVL_W-1:0]  heading;
        turn_dir_t                turn_dir;
        logic [LIMIT_W-1:0]       turn_limit;
    } ddm_stage_t;

endpackage

`default_nettype wire

>>> rtl/core/ddm_cmd_if.sv
// ddm_cmd_if: command channel of the differential drive mixer
// valid/ready handshake with the command fields; depends on ddm_pkg
`default_nettype none

interface ddm_cmd_if
    import ddm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic signed [5:0] speed_delta;
    logic signed [5:0] heading_delta;
    logic signed [6:0] speed_value;
    logic signed [6:0] heading_value;

    modport source (
        output valid, op, speed_delta, heading_delta, speed_value, heading_value,
        input  ready
    );

    modport sink (
        input  valid, op, speed_delta, heading_delta, speed_value, heading_value,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/ddm_res_if.sv
// ddm_res_if: result channel of the differential drive mixer
// valid/ready handshake with the drive and level fields; depends on ddm_pkg
`default_nettype none

interface ddm_res_if
    import ddm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    left_forward;
    logic [CMP_W-1:0]        left_compare;
    logic                    right_forward;
    logic [CMP_W-1:0]        right_compare;
    logic signed [LVL_W-1:0] speed_level;
    logic signed [LVL_W-1:0] heading_level;
    logic [DIR_W-1:0]        turn_direction;
    logic [LIMIT_W-1:0]      turn_threshold;
    logic                    turn_started;

    modport source (
        output valid, left_forward, left_compare, right_forward, right_compare,
               speed_level, heading_level, turn_direction, turn_threshold, turn_started,
        input  ready
    );

    modport sink (
        input  valid, left_forward, left_compare, right_forward, right_compare,
               speed_level, heading_level, turn_direction, turn_threshold, turn_started,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/differential_drive_mixer.sv
// differential drive mixer, top level: trim registers, state stage, mix stage
// a command beat is registered in the state stage, and its result beat then in the mix stage
// throughput: one command per cycle while the result channel is ready, set by the single state update path
// reset clears levels, turn direction, turn threshold, trims and both stage valid flags
// depends on ddm_pkg, ddm_cmd_if, ddm_res_if, ddm_state, ddm_mix
`default_nettype none

module differential_drive_mixer
    import ddm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    ddm_cmd_if.sink                cmd,
    ddm_res_if.source              res,
    input  wire logic              cfg_write,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [TRIM_W-1:0] cfg_data
);

    typedef enum logic [0:0] {
        REG_LEFT_TRIM  = 1'b0,
        REG_RIGHT_TRIM = 1'b1
    } cfg_reg_t;

    logic signed [TRIM_W-1:0] left_trim_reg;
    logic signed [TRIM_W-1:0] right_trim_reg;
    ddm_stage_t               stage;
    logic                     take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_trim_reg  <= '0;
            right_trim_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LEFT_TRIM:  left_trim_reg  <= cfg_data;
                REG_RIGHT_TRIM: right_trim_reg <= cfg_data;
                default:        left_trim_reg  <= left_trim_reg;
            endcase
        end
    end

    ddm_state u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .take  (take),
        .stage (stage)
    );

    ddm_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .left_trim  (left_trim_reg),
        .right_trim (right_trim_reg),
        .take       (take),
        .res        (res)
    );

endmodule

`default_nettype wire

>>> rtl/core/ddm_state.sv
// ddm_state: command decode and level/turn state update
// holds the levels as the first pipeline stage; depends on ddm_pkg, ddm_cmd_if
`default_nettype none

module ddm_state
    import ddm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ddm_cmd_if.sink     cmd,
    input  wire logic   take,
    output ddm_stage_t  stage
);

    localparam int LEVEL_MAX        = 8;
    localparam int LEFT_TURN_STEPS  = 22;
    localparam int RIGHT_TURN_STEPS = 20;
    localparam int LIMIT_MAX        = 1023;
    localparam int PROD_W           = 12;

    function automatic logic signed [LVL_W-1:0] clamp_lvl(input logic signed [6:0] v);
        logic signed [LVL_W-1:0] r;
        if (v > 7'(LEVEL_MAX))
            r = LVL_W'(LEVEL_MAX);
        else if (v < -7'(LEVEL_MAX))
            r = -LVL_W'(LEVEL_MAX);
        else
            r = v[LVL_W-1:0];
        return r;
    endfunction

    logic signed [LVL_W-1:0] speed_reg, speed_next;
    logic signed [LVL_W-1:0] heading_reg, heading_next;
    turn_dir_t               turn_dir_reg, turn_dir_next;
    logic [LIMIT_W-1:0]      turn_limit_reg, turn_limit_next;
    logic                    started_reg, started_next;
    logic                    valid_reg;
    logic                    accept;

    logic [6:0]              turn_mag;
    logic [4:0]              turn_steps;
    logic [PROD_W-1:0]       turn_prod;

    assign cmd.ready = !valid_reg || take;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        turn_mag   = cmd.heading_value[6] ? 7'(-cmd.heading_value) : 7'(cmd.heading_value);
        turn_steps = cmd.heading_value[6] ? 5'(LEFT_TURN_STEPS) : 5'(RIGHT_TURN_STEPS);
        turn_prod  = PROD_W'(turn_mag) * PROD_W'(turn_steps);

        speed_next      = speed_reg;
        heading_next    = heading_reg;
        turn_dir_next   = turn_dir_reg;
        turn_limit_next = turn_limit_reg;
        started_next    = 1'b0;

        unique case (cmd.op)
            OP_ADJUST:
            begin
                speed_next   = clamp_lvl(7'(speed_reg) + 7'(cmd.speed_delta));
                heading_next = clamp_lvl(7'(heading_reg) + 7'(cmd.heading_delta));
            end
            OP_SET_SPD:
            begin
                speed_next = clamp_lvl(cmd.speed_value);
            end
            OP_SET_HDG:
            begin
                heading_next = clamp_lvl(cmd.heading_value);
            end
            OP_RESTORE:
            begin
                if (cmd.speed_value != '0)
                    speed_next = '0;
                if (cmd.heading_value != '0)
                    heading_next = '0;
                turn_dir_next = DIR_NONE;
            end
            OP_TURN:
            begin
                turn_limit_next = (turn_prod > PROD_W'(LIMIT_MAX)) ?
                                  LIMIT_W'(LIMIT_MAX) : turn_prod[LIMIT_W-1:0];
                speed_next      = '0;
                started_next    = 1'b1;
                // zero amount counts as a left turn
                if (cmd.heading_value > 7'sd0)
                begin
                    turn_dir_next = DIR_RIGHT;
                    heading_next  = 5'sd4;
                end
                else
                begin
                    turn_dir_next = DIR_LEFT;
                    heading_next  = -5'sd4;
                end
            end
            default:
            begin
                speed_next = speed_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg      <= '0;
            heading_reg    <= '0;
            turn_dir_reg   <= DIR_NONE;
            turn_limit_reg <= '0;
            started_reg    <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                speed_reg      <= speed_next;
                heading_reg    <= heading_next;
                turn_dir_reg   <= turn_dir_next;
                turn_limit_reg <= turn_limit_next;
                started_reg    <= started_next;
                valid_reg      <= 1'b1;
            end
            else if (take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // the state registers double as the stage payload
    assign stage.valid      = valid_reg;
    assign stage.started    = started_reg;
    assign stage.speed      = speed_reg;
    assign stage.heading    = heading_reg;
    assign stage.turn_dir   = turn_dir_reg;
    assign stage.turn_limit = turn_limit_reg;

endmodule

`default_nettype wire

>>> rtl/core/ddm_mix.sv
// ddm_mix: mixes speed and heading into per-side drive, adds trims,
// and registers the result beat; depends on ddm_pkg, ddm_res_if
`default_nettype none

module ddm_mix
    import ddm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ddm_stage_t               stage,
    input  wire logic signed [TRIM_W-1:0] left_trim,
    input  wire logic signed [TRIM_W-1:0] right_trim,
    output logic                          take,
    ddm_res_if.source                     res
);

    localparam int W          = 12;
    localparam int SPEED_SH   = 5;
    localparam int HEADING_SH = 6;
    localparam int DRIVE_MAX  = 255;
    localparam int RIGHT_BIAS = 5;

    typedef struct packed {
        logic             fwd;
        logic [CMP_W-1:0] cmp;
    } drv_t;

    function automatic logic signed [W-1:0] clamp_drv(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        if (v > W'(DRIVE_MAX))
            r = W'(DRIVE_MAX);
        else if (v < -W'(DRIVE_MAX))
            r = -W'(DRIVE_MAX);
        else
            r = v;
        return r;
    endfunction

    function automatic drv_t to_pwm(input logic signed [W-1:0] v);
        drv_t                r;
        logic signed [W-1:0] nv;
        nv = -v;
        if (v > W'(0))
        begin
            r.fwd = 1'b1;
            r.cmp = (v > W'(DRIVE_MAX)) ? '0 : CMP_W'(DRIVE_MAX) - v[CMP_W-1:0];
        end
        else
        begin
            r.fwd = 1'b0;
            r.cmp = (nv > W'(DRIVE_MAX)) ? CMP_W'(DRIVE_MAX) : nv[CMP_W-1:0];
        end
        return r;
    endfunction

    logic signed [W-1:0] spd, hdg, base, hterm, l_mix, r_mix;
    logic signed [W-1:0] l_coef, r_coef, r_trim, l_prod, r_prod, l_drv, r_drv;
    drv_t                l_pwm, r_pwm;

    logic                    valid_reg;
    drv_t                    left_reg, right_reg;
    logic signed [LVL_W-1:0] speed_reg, heading_reg;
    logic [DIR_W-1:0]        dir_reg;
    logic [LIMIT_W-1:0]      limit_reg;
    logic                    started_reg;

    always_comb
    begin
        spd    = W'(stage.speed);
        hdg    = W'(stage.heading);
        base   = spd <<< SPEED_SH;
        hterm  = hdg <<< HEADING_SH;
        l_mix  = clamp_drv(base - hterm);
        r_mix  = clamp_drv(base + hterm);
        r_trim = W'(right_trim);
        // trim gains folded into one coefficient per side: 2t and 3t + bias
        l_coef = W'(left_trim) <<< 1;
        r_coef = (r_trim <<< 1) + r_trim + W'(RIGHT_BIAS);
        l_prod = spd * l_coef;
        r_prod = spd * r_coef;
        l_drv  = l_mix + l_prod;
        r_drv  = r_mix + r_prod;
        l_pwm  = to_pwm(l_drv);
        r_pwm  = to_pwm(r_drv);
    end

    assign take = stage.valid && (!valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_reg    <= l_pwm;
            right_reg   <= r_pwm;
            speed_reg   <= stage.speed;
            heading_reg <= stage.heading;
            dir_reg     <= stage.turn_dir;
            limit_reg   <= stage.turn_limit;
            started_reg <= stage.started;
        end
    end

    assign res.valid          = valid_reg;
    assign res.left_forward   = left_reg.fwd;
    assign res.left_compare   = left_reg.cmp;
    assign res.right_forward  = right_reg.fwd;
    assign res.right_compare  = right_reg.cmp;
    assign res.speed_level    = speed_reg;
    assign res.heading_level  = heading_reg;
    assign res.turn_direction = dir_reg;
    assign res.turn_threshold = limit_reg;
    assign res.turn_started   = started_reg;

endmodule

`default_nettype wire
